[rtl/core/dss_pkg.sv]
// Shared types, constants and ring pointer helpers for the two-stack engine.
package dss_pkg;

  // Ring size and stored word width.
  localparam int unsigned STACK_DEPTH = 512;
  localparam int unsigned WORD_BITS   = 32;

  // Derived widths: ring index, entry count and pointer sum.
  localparam int unsigned PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  // Fixed field widths of the stream channels.
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 10;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_SWAP     = 3'd1,
    CMD_MOVE     = 3'd2,
    CMD_ROT_UP   = 3'd3,
    CMD_ROT_DOWN = 3'd4
  } cmd_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the input item and issue the ring reads
    logic exec;    // apply the writes and pointer updates
  } ctrl_t;

  // Status from the top level to the controller.
  typedef struct packed {
    logic in_valid;  // an input item is offered
    logic out_busy;  // the output register still holds an untaken item
  } stat_t;

  // One result item.
  typedef struct packed {
    logic signed [VAL_W-1:0] top_first;
    logic signed [VAL_W-1:0] top_second;
    logic [COUNT_W-1:0]      count_first;
    logic [COUNT_W-1:0]      count_second;
    logic                    ignored;
  } res_t;

  // Ring index plus an offset of at most STACK_DEPTH, wrapped once.
  function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] p,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(off);
    if (s >= SUM_W'(STACK_DEPTH)) begin
      s = s - SUM_W'(STACK_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // Ring index minus one, wrapped.
  function automatic logic [PTR_W-1:0] ring_dec(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) begin
      r = PTR_W'(STACK_DEPTH - 1);
    end else begin
      r = p - PTR_W'(1);
    end
    return r;
  endfunction

  // Sign-extend or truncate an input value to a stored word.
  function automatic logic [WORD_BITS-1:0] to_word(logic [VAL_W-1:0] v);
    logic [63:0] w;
    w = {{(64 - VAL_W){v[VAL_W-1]}}, v};
    return w[WORD_BITS-1:0];
  endfunction

  // Report the low bits of a stored word, zero-extended when narrower.
  function automatic logic [VAL_W-1:0] from_word(logic [WORD_BITS-1:0] w);
    logic [63:0] x;
    x = 64'(w);
    return x[VAL_W-1:0];
  endfunction

  // Entry count as the fixed-width count field.
  function automatic logic [COUNT_W-1:0] to_count(logic [CNT_W-1:0] c);
    logic [31:0] x;
    x = 32'(c);
    return x[COUNT_W-1:0];
  endfunction

endpackage

[rtl/core/dual_stack_swap_push_rotate.sv]
// Top level of the two-stack engine: stream ports, controller, datapath, output register.
//
//  Channel   Direction  tdata (low bit up)                              tuser
//  s_axis    in         cmd[2:0], insert_value[34:3], zero pad to 40    which_stack
//  m_axis    out        top_first, top_second, count_first, count_second,
//                       zero pad to 88                                  ignored
//
// Each item has an accept cycle that reads the single-port ring of the
// selected stack, then an execute cycle that writes it and updates heads and counts.
// Reset clears heads and counts at once; the ring stores are not cleared.
// A result waits in the output register; the next item may be accepted
// meanwhile, but its execute cycle holds until the register is taken.
module dual_stack_swap_push_rotate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // cmd, insert_value
  input  logic        s_axis_tuser,   // which_stack
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // top_first, top_second, count_first, count_second
  output logic        m_axis_tuser    // ignored
);
  import dss_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q;

  assign stat.in_valid = s_axis_tvalid;
  assign stat.out_busy = out_valid_q && !m_axis_tready;

  dss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_ready_o (s_axis_tready)
  );

  dss_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cmd_i          (s_axis_tdata[2:0]),
    .which_stack_i  (s_axis_tuser),
    .insert_value_i (s_axis_tdata[34:3]),
    .res_o          (res)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.exec) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (ctrl.exec) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.count_second, out_q.count_first,
                          out_q.top_second, out_q.top_first};
  assign m_axis_tuser  = out_q.ignored;

  // An item accepted while the output is empty runs its execute cycle without stalling, and its result then appears.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |-> ##2 m_axis_tvalid)
    else $error("result did not appear after an unstalled item");

  // No second item is taken while one is executing.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted during execute cycle");

  // An empty first stack reports a zero top.
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[73:64] == '0)) |-> (m_axis_tdata[31:0] == '0))
    else $error("empty first stack reports a non-zero top");

  // Counts never exceed the ring size.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((32'(m_axis_tdata[73:64]) <= STACK_DEPTH) &&
                       (32'(m_axis_tdata[83:74]) <= STACK_DEPTH)))
    else $error("stack count beyond ring size");

endmodule

[rtl/core/dss_ctrl.sv]
// Controller state machine: accepts an item, then runs its execute cycle.
module dss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dss_pkg::stat_t stat_i,
  output dss_pkg::ctrl_t ctrl_o,
  output logic          in_ready_o
);
  import dss_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. Execution waits while the output register is full.
  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (stat_i.in_valid) begin
          ctrl_o.accept = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!stat_i.out_busy) begin
          ctrl_o.exec = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/dss_datapath.sv]
// Datapath: two ring stores, their head and count registers and cached tops.
module dss_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dss_pkg::ctrl_t                  ctrl_i,
  input  logic [2:0]                      cmd_i,
  input  logic                            which_stack_i,
  input  logic [dss_pkg::VAL_W-1:0]       insert_value_i,
  output dss_pkg::res_t                   res_o
);
  import dss_pkg::*;

  // The top entry of each stack lives in top_q; the ring holds entries
  // below it, so the slot at the head may be stale.
  logic [PTR_W-1:0]     head_q [2];
  logic [PTR_W-1:0]     head_d [2];
  logic [CNT_W-1:0]     fill_q [2];
  logic [CNT_W-1:0]     fill_d [2];
  logic [WORD_BITS-1:0] top_q  [2];
  logic [WORD_BITS-1:0] top_d  [2];
  logic [WORD_BITS-1:0] rd_q   [2];

  // Latched command.
  cmd_e                 cmd_q;
  logic                 sel_q;
  logic [WORD_BITS-1:0] val_q;
  logic                 ok_q;

  // Memory port controls.
  logic                 rd_en   [2];
  logic [PTR_W-1:0]     rd_addr [2];
  logic                 wr_en   [2];
  logic [PTR_W-1:0]     wr_addr [2];
  logic [WORD_BITS-1:0] wr_data [2];

  // Pointer arithmetic per stack.
  logic [PTR_W-1:0]     h_inc  [2];
  logic [PTR_W-1:0]     h_dec  [2];
  logic [PTR_W-1:0]     h_fill [2];
  logic [PTR_W-1:0]     h_bot  [2];
  logic                 full   [2];
  logic                 two    [2];

  logic                 in_ok;
  cmd_e                 in_cmd;

  assign in_cmd = cmd_e'(cmd_i);

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      h_inc[s]  = ring_add(head_q[s], CNT_W'(1));
      h_dec[s]  = ring_dec(head_q[s]);
      h_fill[s] = ring_add(head_q[s], fill_q[s]);
      h_bot[s]  = ring_add(head_q[s], fill_q[s] - CNT_W'(1));
      full[s]   = (fill_q[s] == CNT_W'(STACK_DEPTH));
      two[s]    = (fill_q[s] >= CNT_W'(2));
    end
  end

  // Decide at acceptance whether the command takes effect.
  always_comb begin
    case (in_cmd)
      CMD_INSERT:   in_ok = !full[which_stack_i];
      CMD_SWAP:     in_ok = two[which_stack_i];
      CMD_MOVE:     in_ok = (fill_q[which_stack_i] != '0) && !full[!which_stack_i];
      CMD_ROT_UP:   in_ok = two[which_stack_i];
      CMD_ROT_DOWN: in_ok = two[which_stack_i];
      default:      in_ok = 1'b0;
    endcase
  end

  // Capture the command.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q <= in_cmd;
      sel_q <= which_stack_i;
      val_q <= to_word(insert_value_i);
      ok_q  <= in_ok;
    end
  end

  // Read in the accept cycle: bottom entry for rotate down, else the second entry.
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      rd_en[s]   = ctrl_i.accept && (which_stack_i == 1'(s));
      rd_addr[s] = (in_cmd == CMD_ROT_DOWN) ? h_bot[s] : h_inc[s];
    end
  end

  // Execute cycle: one write per ring and the pointer updates.
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      head_d[s]  = head_q[s];
      fill_d[s]  = fill_q[s];
      top_d[s]   = top_q[s];
      wr_en[s]   = 1'b0;
      wr_addr[s] = head_q[s];
      wr_data[s] = top_q[s];
      if (ctrl_i.exec && ok_q) begin
        if (sel_q == 1'(s)) begin
          case (cmd_q)
            CMD_INSERT: begin
              wr_en[s]  = 1'b1;
              head_d[s] = h_dec[s];
              fill_d[s] = fill_q[s] + CNT_W'(1);
              top_d[s]  = val_q;
            end
            CMD_SWAP: begin
              wr_en[s]   = 1'b1;
              wr_addr[s] = h_inc[s];
              top_d[s]   = rd_q[s];
            end
            CMD_MOVE: begin
              head_d[s] = h_inc[s];
              fill_d[s] = fill_q[s] - CNT_W'(1);
              top_d[s]  = rd_q[s];
            end
            CMD_ROT_UP: begin
              wr_en[s]   = 1'b1;
              wr_addr[s] = h_fill[s];
              head_d[s]  = h_inc[s];
              top_d[s]   = rd_q[s];
            end
            CMD_ROT_DOWN: begin
              wr_en[s]  = 1'b1;
              head_d[s] = h_dec[s];
              top_d[s]  = rd_q[s];
            end
            default: begin
              wr_en[s] = 1'b0;
            end
          endcase
        end else if (cmd_q == CMD_MOVE) begin
          // Destination of a move: push the source top.
          wr_en[s]  = 1'b1;
          head_d[s] = h_dec[s];
          fill_d[s] = fill_q[s] + CNT_W'(1);
          top_d[s]  = top_q[1 - s];
        end
      end
    end
  end

  // Pointer and count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        head_q[s] <= '0;
        fill_q[s] <= '0;
      end
    end else begin
      for (int s = 0; s < 2; s++) begin
        head_q[s] <= head_d[s];
        fill_q[s] <= fill_d[s];
      end
    end
  end

  // Cached tops.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 2; s++) begin
      top_q[s] <= top_d[s];
    end
  end

  // One single-port ring store per stack.
  for (genvar g = 0; g < 2; g++) begin : g_ring
    logic [WORD_BITS-1:0] mem_q [STACK_DEPTH];

    always_ff @(posedge clk_i) begin
      if (wr_en[g]) begin
        mem_q[wr_addr[g]] <= wr_data[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rd_en[g]) begin
        rd_q[g] <= mem_q[rd_addr[g]];
      end
    end
  end

  // Result from the state after this command.
  always_comb begin
    res_o.top_first    = (fill_d[0] == '0) ? '0 : from_word(top_d[0]);
    res_o.top_second   = (fill_d[1] == '0) ? '0 : from_word(top_d[1]);
    res_o.count_first  = to_count(fill_d[0]);
    res_o.count_second = to_count(fill_d[1]);
    res_o.ignored      = !ok_q;
  end

endmodule
